[rtl/core/windowed_event_rate_meter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the event rate meter
// Concurrent checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_EVENT_RATE_METER_MACROS_SVH
`define WINDOWED_EVENT_RATE_METER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WRM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wrm assertion failed");
// next-cycle implication
`define WRM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wrm assertion failed");
`else
`define WRM_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define WRM_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/wrm_pkg.sv]
// ----------------------------------------------------------------------------
// wrm_pkg
// Widths, reset values and shared types of the event rate meter.
// ----------------------------------------------------------------------------
package wrm_pkg;

    localparam int TS_W             = 48;
    localparam int CNT_W            = 32;
    localparam int TPS_W            = 32;
    localparam int RATE_W           = 40;
    localparam int FRAC_W           = 8;
    localparam int PROD_W           = CNT_W + TPS_W;
    localparam int DIV_STEPS        = RATE_W;
    localparam int WINDOW_DEPTH_DEF = 16;

    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 4;
    // register select: byte address bit 3 (registers 8 bytes apart)
    localparam int REG_SEL_BIT = 3;
    localparam logic REG_ORIGIN = 1'b0;
    localparam logic REG_TPS    = 1'b1;

    localparam logic [TPS_W-1:0]  TPS_RESET = 32'd1000000000;
    localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};

    typedef struct packed {
        logic push;
        logic rd_en;
    } ring_ctrl_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [TS_W-1:0]   den;
    } div_req_t;

endpackage

[rtl/core/wrm_if.sv]
// ----------------------------------------------------------------------------
// wrm_if
// Valid/ready channels carrying sample items in and rate items out.
// ----------------------------------------------------------------------------
interface wrm_in_if;
    import wrm_pkg::*;

    logic             valid;
    logic             ready;
    logic [TS_W-1:0]  timestamp;
    logic [CNT_W-1:0] token_total;

    modport source (output valid, timestamp, token_total, input ready);
    modport sink   (input valid, timestamp, token_total, output ready);
endinterface

interface wrm_out_if;
    import wrm_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] overall_rate;
    logic [RATE_W-1:0] window_rate;

    modport source (output valid, overall_rate, window_rate, input ready);
    modport sink   (input valid, overall_rate, window_rate, output ready);
endinterface

[rtl/core/wrm_divider.sv]
// ----------------------------------------------------------------------------
// wrm_divider
// Restoring divider: floor(num * 256 / den) saturated to 40 bits, one
// quotient bit per cycle. Zero divisor gives zero.
// ----------------------------------------------------------------------------
module wrm_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wrm_pkg::div_req_t           req,
    output logic                        done,
    output logic [wrm_pkg::RATE_W-1:0]  quo
);
    import wrm_pkg::*;

`include "windowed_event_rate_meter_macros.svh"

    localparam int HI_W   = RATE_W - FRAC_W;
    localparam int LO_W   = PROD_W - HI_W;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [TS_W-1:0]   rem_reg;
    logic [TS_W-1:0]   den_reg;
    logic [RATE_W-1:0] sh_reg;

    logic [TS_W:0]     trial;
    logic [TS_W:0]     diff;
    logic              fits;
    logic [TS_W-1:0]   rem_next;
    logic [TS_W-1:0]   num_hi;
    logic              sat;

    assign trial    = {rem_reg, sh_reg[RATE_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? diff[TS_W-1:0] : trial[TS_W-1:0];

    // quotient reaches 2^40 exactly when num >= den * 2^32
    assign num_hi = {{(TS_W-HI_W){1'b0}}, req.num[PROD_W-1 -: HI_W]};
    assign sat    = num_hi >= req.den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.den == '0 || sat)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_W'(DIV_STEPS);
                end
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.den;
            rem_reg <= num_hi;
            if (req.den == '0)
                sh_reg <= '0;
            else if (sat)
                sh_reg <= RATE_MAX;
            else
                sh_reg <= {req.num[LO_W-1:0], {FRAC_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= {sh_reg[RATE_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

    `WRM_ASSERT_IMPL(a_rem_below_den, clk, rst_n, busy_reg, rem_reg < den_reg)
    `WRM_ASSERT_IMPL(a_no_start_busy, clk, rst_n, req.start, !busy_reg)

endmodule

[rtl/core/wrm_ring.sv]
// ----------------------------------------------------------------------------
// wrm_ring
// Timestamp ring with write slot, saturating fill count and a registered
// read port for the oldest held stamp.
// ----------------------------------------------------------------------------
module wrm_ring #(
    parameter int DEPTH = wrm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wrm_pkg::ring_ctrl_t          ctrl,
    input  logic [wrm_pkg::TS_W-1:0]     wr_stamp,
    output logic [$clog2(DEPTH+1)-1:0]   fill,
    output logic [wrm_pkg::TS_W-1:0]     rd_stamp
);
    import wrm_pkg::*;

`include "windowed_event_rate_meter_macros.svh"

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [TS_W-1:0]   mem [DEPTH];
    logic [IDX_W-1:0]  slot_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [TS_W-1:0]   rd_reg;

    logic [IDX_W-1:0]  slot_next;
    logic [IDX_W-1:0]  rd_addr;
    logic              full_after;

    assign slot_next  = (slot_reg == IDX_W'(DEPTH - 1)) ? '0 : slot_reg + IDX_W'(1);
    // until the ring wraps the oldest stamp sits in slot zero
    assign full_after = fill_reg >= FILL_W'(DEPTH - 1);
    assign rd_addr    = full_after ? slot_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else if (ctrl.push)
        begin
            slot_reg <= slot_next;
            if (fill_reg != FILL_W'(DEPTH))
                fill_reg <= fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[slot_reg] <= wr_stamp;
        if (ctrl.rd_en)
            rd_reg <= mem[rd_addr];
    end

    assign fill     = fill_reg;
    assign rd_stamp = rd_reg;

    `WRM_ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_reg <= FILL_W'(DEPTH))

endmodule

[rtl/core/windowed_event_rate_meter.sv]
// ----------------------------------------------------------------------------
// windowed_event_rate_meter
// Overall token rate and sliding-window item rate, unsigned Q32.8 per second.
// ----------------------------------------------------------------------------
// Input channel item_in carries a tick timestamp and a cumulative token count;
// output channel rate_out returns one item per input with overall_rate and
// window_rate. The APB port sets the origin tick (address 0) and
// ticks_per_second (address 8); write it only while the block is idle.
// An item with a nonzero count takes, per rate, one 32x32 multiply and
// one 40-step pass of the shared restoring divider; saturating or
// zero-span divisions skip the steps. A zero count skips both rates and
// returns zero rates. item_in.ready is high only while the sequencer
// is idle, so one item is in work at a time. The result sits in an
// output register; the next item may be accepted while it waits, and
// the sequencer holds its finished result until rate_out is free.
// Reset empties the timestamp ring and fill count, clears the origin
// tick and loads ticks_per_second with 1e9.
// ----------------------------------------------------------------------------
module windowed_event_rate_meter #(
    parameter int WINDOW_DEPTH = wrm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    wrm_in_if.sink                            item_in,
    wrm_out_if.source                         rate_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wrm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [wrm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wrm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import wrm_pkg::*;

`include "windowed_event_rate_meter_macros.svh"

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL_O     = 3'd1;
    localparam logic [2:0] S_DIVO_GO   = 3'd2;
    localparam logic [2:0] S_DIVO_WAIT = 3'd3;
    localparam logic [2:0] S_MUL_W     = 3'd4;
    localparam logic [2:0] S_DIVW_GO   = 3'd5;
    localparam logic [2:0] S_DIVW_WAIT = 3'd6;
    localparam logic [2:0] S_FINISH    = 3'd7;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [TS_W-1:0]   origin_reg;
    logic [TPS_W-1:0]  tps_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TS_W-1:0]   den_reg;
    logic [RATE_W-1:0] overall_reg;
    logic [RATE_W-1:0] window_reg;
    logic              out_valid_reg;
    logic [RATE_W-1:0] out_overall_reg;
    logic [RATE_W-1:0] out_window_reg;

    logic              in_take;
    logic              out_load;
    logic              cfg_wr;
    logic              div_wait;
    logic [CNT_W-1:0]  mul_a;
    logic [PROD_W-1:0] mul_p;
    logic [TS_W-1:0]   sub_b;
    logic              span_ok;
    logic [TS_W-1:0]   den_next;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] fill_m1;
    logic [TS_W-1:0]   oldest;
    logic              div_done;
    logic [RATE_W-1:0] div_quo;
    ring_ctrl_t        ring_ctrl;
    div_req_t          div_req;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            tps_reg    <= TPS_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[REG_SEL_BIT] == REG_TPS)
                tps_reg <= pwdata[TPS_W-1:0];
            else
                origin_reg <= pwdata[TS_W-1:0];
        end
    end

    assign prdata = (paddr[REG_SEL_BIT] == REG_ORIGIN)
                  ? {{(APB_DATA_W-TS_W){1'b0}}, origin_reg}
                  : {{(APB_DATA_W-TPS_W){1'b0}}, tps_reg};

    // ---------------- shared multiply and span ----------------
    assign fill_m1 = fill - FILL_W'(1);
    assign mul_a   = (state_reg == S_MUL_O) ? cnt_reg
                                            : {{(CNT_W-FILL_W){1'b0}}, fill_m1};
    assign mul_p   = PROD_W'(mul_a) * PROD_W'(tps_reg);

    assign sub_b    = (state_reg == S_MUL_O) ? origin_reg : oldest;
    assign span_ok  = (state_reg == S_MUL_O) || (fill >= FILL_W'(2));
    assign den_next = (span_ok && ts_reg > sub_b) ? ts_reg - sub_b : '0;

    // ---------------- ring and divider ----------------
    assign ring_ctrl.push  = (state_reg == S_MUL_O);
    assign ring_ctrl.rd_en = (state_reg == S_MUL_O);

    wrm_ring #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ring_ctrl),
        .wr_stamp (ts_reg),
        .fill     (fill),
        .rd_stamp (oldest)
    );

    assign div_req.start = (state_reg == S_DIVO_GO) || (state_reg == S_DIVW_GO);
    assign div_req.num   = prod_reg;
    assign div_req.den   = den_reg;

    wrm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // ---------------- sequencer ----------------
    assign item_in.ready = (state_reg == S_IDLE);
    assign in_take       = item_in.valid && item_in.ready;
    assign out_load      = (state_reg == S_FINISH) && (!out_valid_reg || rate_out.ready);
    assign div_wait      = (state_reg == S_DIVO_WAIT) || (state_reg == S_DIVW_WAIT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                    state_next = (item_in.token_total == '0) ? S_FINISH : S_MUL_O;
            end
            S_MUL_O:     state_next = S_DIVO_GO;
            S_DIVO_GO:   state_next = S_DIVO_WAIT;
            S_DIVO_WAIT:
            begin
                if (div_done)
                    state_next = S_MUL_W;
            end
            S_MUL_W:     state_next = S_DIVW_GO;
            S_DIVW_GO:   state_next = S_DIVW_WAIT;
            S_DIVW_WAIT:
            begin
                if (div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rate_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ts_reg      <= item_in.timestamp;
            cnt_reg     <= item_in.token_total;
            overall_reg <= '0;
            window_reg  <= '0;
        end
        if (state_reg == S_MUL_O || state_reg == S_MUL_W)
        begin
            prod_reg <= mul_p;
            den_reg  <= den_next;
        end
        if (state_reg == S_DIVO_WAIT && div_done)
            overall_reg <= div_quo;
        if (state_reg == S_DIVW_WAIT && div_done)
            window_reg <= div_quo;
        if (out_load)
        begin
            out_overall_reg <= overall_reg;
            out_window_reg  <= window_reg;
        end
    end

    assign rate_out.valid        = out_valid_reg;
    assign rate_out.overall_rate = out_overall_reg;
    assign rate_out.window_rate  = out_window_reg;

    `WRM_ASSERT_IMPL(a_done_in_wait, clk, rst_n, div_done, div_wait)
    `WRM_ASSERT_IMPL(a_valid_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_FINISH)

endmodule
